[rtl/lrupr_pkg.sv]
// Shared types and constants for the LRU page replacement block.
// Used by lrupr_cell, lrupr_skid and lru_page_replacement.
package lrupr_pkg;

  localparam int MAX_FRAMES_DEF = 8;
  localparam int PAGE_W         = 16;
  localparam int COUNT_W        = 16;
  localparam int FRAMES_W       = 4;
  localparam int PADDR_W        = 3;
  localparam int PDATA_W        = 32;

  // register byte addresses
  localparam logic [PADDR_W-1:0] ADDR_FRAMES_IN_USE = 3'd0;

  typedef struct packed {
    logic [PAGE_W-1:0] page_number;
    logic              last_reference;
  } ref_t;

  typedef struct packed {
    logic               hit;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [COUNT_W-1:0] fault_count;
    logic               run_done;
  } res_t;

  // broadcast to every cell for the current beat
  typedef struct packed {
    logic              en;
    logic              rotate;
    logic              append;
    logic [PAGE_W-1:0] page;
  } cell_ctrl_t;

  // where a cell sits relative to the occupied part of the list
  typedef struct packed {
    logic live;       // holds a resident page
    logic tail;       // most recent resident page
    logic free_slot;  // first empty frame
  } cell_pos_t;

endpackage

[rtl/lru_page_replacement.sv]
// LRU page replacement: top level with config register, occupancy and fault
// counters, the chain of frame cells and the result buffer.
// Depends on lrupr_pkg, lrupr_cell, lrupr_skid.
//
//   channel   dir  handshake            payload
//   ref       in   ref_valid/ref_ready  ref_data (lrupr_pkg::ref_t)
//   res       out  res_valid/res_ready  res_data (lrupr_pkg::res_t)
//   apb       in   psel/penable/pready  paddr, pwrite, pwdata, prdata
//
// One reference per cycle while ref_ready is high. All frames compare in
// parallel; those from the removed page up shift one place in the same
// cycle. rst clears occupancy, fault count, frame setting (to 1) and the
// buffer. Each result is registered in the output buffer and stays there
// while stalled; ref_ready drops only when both entries are held.
module lru_page_replacement #(
  parameter int MAX_FRAMES = lrupr_pkg::MAX_FRAMES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lrupr_pkg::PADDR_W-1:0] paddr,
  input  logic [lrupr_pkg::PDATA_W-1:0] pwdata,
  output logic [lrupr_pkg::PDATA_W-1:0] prdata,
  output logic                          pready,
  input  logic                          ref_valid,
  output logic                          ref_ready,
  input  lrupr_pkg::ref_t               ref_data,
  output logic                          res_valid,
  input  logic                          res_ready,
  output lrupr_pkg::res_t               res_data
);

  localparam int OCC_W = $clog2(MAX_FRAMES + 1);
  localparam int CW    = (OCC_W > lrupr_pkg::FRAMES_W) ? OCC_W : lrupr_pkg::FRAMES_W;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_FRAMES);

  logic [lrupr_pkg::FRAMES_W-1:0] frames_in_use;
  logic [OCC_W-1:0]               occ;
  logic [OCC_W-1:0]               occ_next;
  logic [lrupr_pkg::COUNT_W-1:0]  faults;
  logic [lrupr_pkg::COUNT_W-1:0]  faults_next;

  logic [CW-1:0] fiu_c;
  logic [CW-1:0] cap;
  logic          full;
  logic          accept;
  logic          hit;
  logic          evict;

  lrupr_pkg::cell_ctrl_t ctrl;
  lrupr_pkg::res_t       result;

  logic [MAX_FRAMES-1:0]                   match;
  logic [MAX_FRAMES:0]                     seen;
  logic [lrupr_pkg::PAGE_W-1:0]            entry [MAX_FRAMES];

  // config port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= lrupr_pkg::FRAMES_W'(1);
    end else if (psel && penable && pwrite && paddr == lrupr_pkg::ADDR_FRAMES_IN_USE) begin
      frames_in_use <= pwdata[lrupr_pkg::FRAMES_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == lrupr_pkg::ADDR_FRAMES_IN_USE) begin
      prdata = lrupr_pkg::PDATA_W'(frames_in_use);
    end
  end

  // capacity: zero acts as one, anything above the frame count clamps
  assign fiu_c = CW'(frames_in_use);
  always_comb begin
    if (fiu_c == '0) begin
      cap = CW'(1);
    end else if (fiu_c > MAX_C) begin
      cap = MAX_C;
    end else begin
      cap = fiu_c;
    end
  end

  assign full   = CW'(occ) >= cap;
  assign accept = ref_valid && ref_ready;
  assign hit    = |match;
  assign evict  = !hit && full;

  assign ctrl.en     = accept;
  assign ctrl.rotate = hit || evict;
  assign ctrl.append = !hit && !full;
  assign ctrl.page   = ref_data.page_number;

  // on an eviction the oldest frame is the one removed
  assign seen[0] = evict;

  genvar i;
  generate
    for (i = 0; i < MAX_FRAMES; i++) begin : g_cell
      localparam logic [OCC_W-1:0] IDX  = OCC_W'(i);
      localparam logic [OCC_W-1:0] IDX1 = OCC_W'(i + 1);
      lrupr_pkg::cell_pos_t        pos;
      logic [lrupr_pkg::PAGE_W-1:0] neighbor;

      assign pos.live      = occ > IDX;
      assign pos.tail      = occ == IDX1;
      assign pos.free_slot = occ == IDX;

      if (i + 1 < MAX_FRAMES) begin : g_mid
        assign neighbor = entry[i + 1];
      end else begin : g_end
        assign neighbor = '0;
      end

      lrupr_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .pos      (pos),
        .seen_in  (seen[i]),
        .neighbor (neighbor),
        .entry    (entry[i]),
        .match    (match[i]),
        .seen_out (seen[i + 1])
      );
    end
  endgenerate

  assign faults_next = (evict && faults != '1) ? faults + 1'b1 : faults;
  assign occ_next    = ctrl.append ? occ + 1'b1 : occ;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ    <= '0;
      faults <= '0;
    end else if (accept) begin
      if (ref_data.last_reference) begin
        occ    <= '0;
        faults <= '0;
      end else begin
        occ    <= occ_next;
        faults <= faults_next;
      end
    end
  end

  always_comb begin
    result.hit           = hit;
    result.evicted_valid = evict;
    result.evicted_page  = evict ? entry[0] : '0;
    result.fault_count   = faults_next;
    result.run_done      = ref_data.last_reference;
  end

  lrupr_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ref_valid),
    .in_ready  (ref_ready),
    .in_data   (result),
    .out_valid (res_valid),
    .out_ready (res_ready),
    .out_data  (res_data)
  );

endmodule

[rtl/lrupr_cell.sv]
// One frame of the recency chain: holds a page, compares it with the
// reference, takes its younger neighbor's page on a rotate and loads
// the reference page as tail or free slot. Depends on lrupr_pkg.
module lrupr_cell (
  input  logic                        clk,
  input  lrupr_pkg::cell_ctrl_t       ctrl,
  input  lrupr_pkg::cell_pos_t        pos,
  input  logic                        seen_in,
  input  logic [lrupr_pkg::PAGE_W-1:0] neighbor,
  output logic [lrupr_pkg::PAGE_W-1:0] entry,
  output logic                        match,
  output logic                        seen_out
);

  logic [lrupr_pkg::PAGE_W-1:0] entry_next;
  logic                         load;

  assign match    = pos.live && (entry == ctrl.page);
  // seen: the removed page sits at or below this frame
  assign seen_out = seen_in | match;

  always_comb begin
    entry_next = entry;
    load       = 1'b0;
    if (ctrl.rotate && seen_out && pos.live && !pos.tail) begin
      entry_next = neighbor;
      load       = 1'b1;
    end else if ((ctrl.rotate && pos.tail) || (ctrl.append && pos.free_slot)) begin
      entry_next = ctrl.page;
      load       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en && load) begin
      entry <= entry_next;
    end
  end

endmodule

[rtl/lrupr_skid.sv]
// Two-entry result buffer: output register plus skid register, so the
// input side can take one more beat while a result waits. Depends on lrupr_pkg.
module lrupr_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  lrupr_pkg::res_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output lrupr_pkg::res_t  out_data
);

  logic            main_valid;
  logic            skid_valid;
  lrupr_pkg::res_t main_data;
  lrupr_pkg::res_t skid_data;
  logic            push;
  logic            pop;

  assign in_ready  = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;
  assign push      = in_valid && in_ready;
  assign pop       = main_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        main_data  <= skid_data;
        skid_valid <= 1'b0;
      end else if (push) begin
        main_data <= in_data;
      end else begin
        main_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_data  <= in_data;
        main_valid <= 1'b1;
      end else begin
        skid_data  <= in_data;
        skid_valid <= 1'b1;
      end
    end
  end

endmodule
